[rtl/mbtm_pkg.sv]
package mbtm_pkg;

  typedef enum logic [1:0] {
    REQ_READ_INPUTS = 2'd0,
    REQ_READ_COIL   = 2'd1,
    REQ_WRITE_COIL  = 2'd2,
    REQ_READ_REGS   = 2'd3
  } req_kind_e;

  typedef enum logic [1:0] {
    OUT_TX_BYTE = 2'd0,
    OUT_BIT     = 2'd1,
    OUT_REG     = 2'd2,
    OUT_END     = 2'd3
  } out_kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ID_BAD    = 3'd1,
    ST_CODE_BAD  = 3'd2,
    ST_ECHO_BAD  = 3'd3,
    ST_SHORT     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_HEADER = 3'b010,
    PH_PDU    = 3'b100
  } phase_e;

  localparam logic [7:0]  FC_READ_INPUTS = 8'h02;
  localparam logic [7:0]  FC_READ_COIL   = 8'h01;
  localparam logic [7:0]  FC_WRITE_COIL  = 8'h05;
  localparam logic [7:0]  FC_READ_REGS   = 8'h04;
  localparam logic [15:0] COIL_ON        = 16'hFF00;
  localparam logic [15:0] COIL_OFF       = 16'h0000;
  localparam logic [7:0]  LEN_FIELD      = 8'h06;
  localparam logic [7:0]  UNIT_RESET     = 8'h01;
  localparam logic [15:0] TID_RESET      = 16'h0001;
  localparam logic [11:0] BYTE_ROUND     = 12'd7;
  localparam int unsigned TX_BYTES       = 12;

  // Descriptor of the result items one input item causes
  typedef struct packed {
    logic          tx;      // request frame bytes
    logic          bits;    // unpacked bits, else one register word
    logic [15:0]   word;
    logic [10:0]   base;
    logic [3:0]    ndata;
    logic          fin;     // closing transaction-end item
    status_e       status;
    logic [10:0]   endcnt;
    logic [15:0]   tid;
    logic [7:0]    unit;
    logic [7:0]    code;
    logic [15:0]   addr;
  } emit_t;

  function automatic logic [7:0] fcode(req_kind_e k);
    logic [7:0] c;
    case (k)
      REQ_READ_INPUTS: c = FC_READ_INPUTS;
      REQ_READ_COIL:   c = FC_READ_COIL;
      REQ_WRITE_COIL:  c = FC_WRITE_COIL;
      REQ_READ_REGS:   c = FC_READ_REGS;
      default:         c = FC_READ_INPUTS;
    endcase
    return c;
  endfunction

endpackage

[rtl/modbus_tcp_master_framer.sv]
// Channel   Direction  tdata / tuser / tlast
// s_axis    in         tdata: request_kind, start_address, quantity, coil_value, rx_byte
//                      tuser: func
// m_axis    out        tdata: out_data, item_position, status; tuser: out_kind; tlast: last
// cfg       in         cfg_data_i: unit_identifier
//
// Each input item is decoded in the cycle it is accepted; its result items then
// leave one per cycle from the emit register while m_axis is ready (12 for a request,
// up to 9 for a byte). An item that causes at most one result is taken every cycle while
// m_axis is ready; a new item is taken in the cycle the prior item's last result leaves.
// Reset clears the parser to idle, the transaction id to 1 and the unit id to 1.
// A stall on m_axis holds the current result and back-pressures s_axis.
module modbus_tcp_master_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] request_kind, [17:2] start_address, [28:18] quantity, [29] coil_value,
  // [37:30] rx_byte, [39:38] zero
  input  logic [39:0] s_axis_tdata,
  // [0] func
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] out_data, [26:16] item_position, [29:27] status, [31:30] zero
  output logic [31:0] m_axis_tdata,
  // [1:0] out_kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  import mbtm_pkg::*;

  logic [7:0]  unit_q;
  logic [15:0] tc_q, tc_d;
  phase_e      phase_q, phase_d;
  logic [15:0] bpos_q, bpos_d;
  req_kind_e   kind_q, kind_d;
  logic [15:0] addr_q, addr_d;
  logic [10:0] qty_q, qty_d;
  logic        coil_q, coil_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  hbl_q, hbl_d;
  logic [10:0] dcnt_q, dcnt_d;
  logic        bad_q, bad_d;

  emit_t       em_q, em_d;
  logic        busy_q;
  logic [3:0]  idx_q;
  logic [3:0]  tot_q;
  logic [3:0]  tot_d;
  logic        last_res;
  logic        in_acc;
  logic        out_acc;

  logic        fin;
  status_e     fin_status;
  req_kind_e   in_kind;
  logic [10:0] in_qty;
  logic        in_coil;
  logic [15:0] in_addr;
  logic [7:0]  rxb;
  logic [15:0] coil_w;
  logic [15:0] req_w;
  logic [15:0] p;
  logic [7:0]  echo;
  logic [11:0] cnt_bytes;
  logic [10:0] rem;
  logic [3:0]  nb;
  logic [15:0] len;

  out_kind_e   o_kind;
  logic [15:0] o_data;
  logic [10:0] o_pos;
  status_e     o_status;
  logic [7:0]  tx_byte;

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = busy_q;
  assign last_res      = (idx_q == (tot_q - 4'd1));
  assign out_acc       = busy_q && m_axis_tready;
  assign s_axis_tready = !busy_q || (m_axis_tready && last_res);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign in_kind = req_kind_e'(s_axis_tdata[1:0]);
  assign in_addr = s_axis_tdata[17:2];
  assign in_qty  = s_axis_tdata[28:18];
  assign in_coil = s_axis_tdata[29];
  assign rxb     = s_axis_tdata[37:30];
  assign coil_w  = coil_q ? COIL_ON : COIL_OFF;
  assign p       = bpos_q;
  assign rem     = qty_q - dcnt_q;
  assign nb      = (rem >= 11'd8) ? 4'd8 : rem[3:0];
  assign len     = {hbl_q, rxb};
  assign cnt_bytes = ({1'b0, qty_q} + BYTE_ROUND) >> 3;

  always_comb begin
    case (p)
      16'd0:   echo = FC_WRITE_COIL;
      16'd1:   echo = addr_q[15:8];
      16'd2:   echo = addr_q[7:0];
      16'd3:   echo = coil_w[15:8];
      default: echo = coil_w[7:0];
    endcase
  end

  always_comb begin
    tc_d    = tc_q;
    phase_d = phase_q;
    bpos_d  = bpos_q;
    kind_d  = kind_q;
    addr_d  = addr_q;
    qty_d   = qty_q;
    coil_d  = coil_q;
    left_d  = left_q;
    hbl_d   = hbl_q;
    dcnt_d  = dcnt_q;
    bad_d   = bad_q;
    fin        = 1'b0;
    fin_status = ST_OK;
    req_w      = '0;
    em_d        = '0;
    em_d.status = ST_OK;
    if (in_acc) begin
      if (!s_axis_tuser) begin
        kind_d = in_kind;
        addr_d = in_addr;
        coil_d = in_coil;
        qty_d  = (in_kind == REQ_READ_COIL || in_kind == REQ_WRITE_COIL) ? 11'd1 : in_qty;
        req_w  = (in_kind == REQ_WRITE_COIL) ? (in_coil ? COIL_ON : COIL_OFF)
                                             : {5'd0, qty_d};
        em_d.tx    = 1'b1;
        em_d.ndata = 4'(TX_BYTES);
        em_d.word  = req_w;
        em_d.tid   = tc_q;
        em_d.unit  = unit_q;
        em_d.code  = fcode(in_kind);
        em_d.addr  = in_addr;
        phase_d = PH_HEADER;
        bpos_d  = '0;
        left_d  = '0;
        hbl_d   = '0;
        dcnt_d  = '0;
        bad_d   = 1'b0;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            bpos_d = bpos_q + 16'd1;
            if (p == 16'd0 || p == 16'd2 || p == 16'd4) begin
              hbl_d = rxb;
            end else if (p == 16'd1) begin
              if (len != tc_q) begin
                fin        = 1'b1;
                fin_status = ST_ID_BAD;
                bpos_d     = bpos_q;
              end
            end else if (p == 16'd5) begin
              left_d = (len != 16'd0) ? len - 16'd1 : 16'd0;
            end else if (p != 16'd3) begin
              tc_d   = tc_q + 16'd1;
              bpos_d = '0;
              if (left_q == 16'd0) begin
                fin        = 1'b1;
                fin_status = ST_SHORT;
              end else begin
                phase_d = PH_PDU;
              end
            end
          end
          PH_PDU: begin
            left_d = left_q - 16'd1;
            if (bpos_q != 16'hFFFF) bpos_d = bpos_q + 16'd1;
            if (kind_q == REQ_WRITE_COIL) begin
              if (p >= 16'd5 || rxb != echo) bad_d = 1'b1;
              if (left_d == 16'd0) begin
                fin        = 1'b1;
                fin_status = (p < 16'd4) ? ST_SHORT : (bad_d ? ST_ECHO_BAD : ST_OK);
              end
            end else begin
              if (p == 16'd0) begin
                if (rxb != fcode(kind_q)) begin
                  fin        = 1'b1;
                  fin_status = ST_CODE_BAD;
                end
              end else if (p == 16'd1) begin
                if ((kind_q == REQ_READ_INPUTS && {4'd0, rxb} != cnt_bytes) ||
                    (kind_q == REQ_READ_COIL && rxb == 8'd0) ||
                    (kind_q == REQ_READ_REGS && {4'd0, rxb} != {qty_q, 1'b0})) begin
                  fin        = 1'b1;
                  fin_status = ST_CODE_BAD;
                end else if (kind_q != REQ_READ_COIL && qty_q == 11'd0) begin
                  fin = 1'b1;
                end
              end else if (kind_q == REQ_READ_INPUTS) begin
                em_d.bits  = 1'b1;
                em_d.word  = {8'd0, rxb};
                em_d.base  = dcnt_q;
                em_d.ndata = nb;
                dcnt_d     = dcnt_q + {7'd0, nb};
                if (rem <= 11'd8) fin = 1'b1;
              end else if (kind_q == REQ_READ_COIL) begin
                em_d.bits  = 1'b1;
                em_d.word  = {15'd0, rxb[0]};
                em_d.ndata = 4'd1;
                dcnt_d     = 11'd1;
                fin        = 1'b1;
              end else if (!p[0]) begin
                hbl_d = rxb;
              end else begin
                em_d.word  = len;
                em_d.base  = dcnt_q;
                em_d.ndata = 4'd1;
                dcnt_d     = dcnt_q + 11'd1;
                if (dcnt_d >= qty_q) fin = 1'b1;
              end
              // out of PDU bytes before the frame is complete
              if (!fin && left_d == 16'd0) begin
                fin        = 1'b1;
                fin_status = ST_SHORT;
              end
            end
          end
          default: ;
        endcase
        if (fin) begin
          phase_d     = PH_IDLE;
          em_d.fin    = 1'b1;
          em_d.status = fin_status;
          em_d.endcnt = dcnt_d;
        end
      end
    end
  end

  assign tot_d = em_d.ndata + {3'd0, em_d.fin};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q  <= UNIT_RESET;
      tc_q    <= TID_RESET;
      phase_q <= PH_IDLE;
      bpos_q  <= '0;
      kind_q  <= REQ_READ_INPUTS;
      addr_q  <= '0;
      qty_q   <= '0;
      coil_q  <= 1'b0;
      left_q  <= '0;
      hbl_q   <= '0;
      dcnt_q  <= '0;
      bad_q   <= 1'b0;
      busy_q  <= 1'b0;
      idx_q   <= '0;
      tot_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) unit_q <= cfg_data_i;
      tc_q    <= tc_d;
      phase_q <= phase_d;
      bpos_q  <= bpos_d;
      kind_q  <= kind_d;
      addr_q  <= addr_d;
      qty_q   <= qty_d;
      coil_q  <= coil_d;
      left_q  <= left_d;
      hbl_q   <= hbl_d;
      dcnt_q  <= dcnt_d;
      bad_q   <= bad_d;
      if (in_acc) begin
        busy_q <= (tot_d != 4'd0);
        idx_q  <= '0;
        tot_q  <= tot_d;
      end else if (out_acc) begin
        if (last_res) busy_q <= 1'b0;
        else idx_q <= idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) em_q <= em_d;
  end

  always_comb begin
    case (idx_q)
      4'd0:    tx_byte = em_q.tid[15:8];
      4'd1:    tx_byte = em_q.tid[7:0];
      4'd5:    tx_byte = LEN_FIELD;
      4'd6:    tx_byte = em_q.unit;
      4'd7:    tx_byte = em_q.code;
      4'd8:    tx_byte = em_q.addr[15:8];
      4'd9:    tx_byte = em_q.addr[7:0];
      4'd10:   tx_byte = em_q.word[15:8];
      4'd11:   tx_byte = em_q.word[7:0];
      default: tx_byte = 8'd0;
    endcase
  end

  always_comb begin
    o_status = ST_OK;
    if (idx_q < em_q.ndata) begin
      if (em_q.tx) begin
        o_kind = OUT_TX_BYTE;
        o_data = {8'd0, tx_byte};
        o_pos  = '0;
      end else if (em_q.bits) begin
        o_kind = OUT_BIT;
        o_data = {15'd0, em_q.word[idx_q[2:0]]};
        o_pos  = em_q.base + {7'd0, idx_q};
      end else begin
        o_kind = OUT_REG;
        o_data = em_q.word;
        o_pos  = em_q.base;
      end
    end else begin
      o_kind   = OUT_END;
      o_data   = '0;
      o_pos    = em_q.endcnt;
      o_status = em_q.status;
    end
  end

  assign m_axis_tdata = {2'b00, o_status, o_pos, o_data};
  assign m_axis_tuser = o_kind;
  assign m_axis_tlast = last_res;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < tot_q))
    else $error("emit index beyond result count");

  a_take_only_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready && busy_q) |-> (m_axis_tready && m_axis_tlast))
    else $error("input taken while results still pending");

  a_status_on_end_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != OUT_END) |-> (m_axis_tdata[29:27] == ST_OK))
    else $error("status on a non-end item");

  a_tid_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(tc_q) |-> $past(phase_q == PH_HEADER && in_acc && s_axis_tuser))
    else $error("transaction id moved outside header parsing");

endmodule
